### src/three_axis_pid_force_controller_top_assert.svh
// Assertion macros shared by the checker of the three-axis PID force controller.
// Depends on nothing; the including scope supplies clk and rst.
`ifndef THREE_AXIS_PID_FORCE_CONTROLLER_TOP_ASSERT_SVH
`define THREE_AXIS_PID_FORCE_CONTROLLER_TOP_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define TPFC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define TPFC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/tpfc_pkg.sv
// Shared types, widths and constants of the three-axis PID force controller.
// Used by the lane, merge and top-level modules; depends on nothing.
package tpfc_pkg;

  localparam int AXES      = 3;
  localparam int POS_W     = 19;
  localparam int ERR_W     = 20;
  localparam int CHG_W     = 21;
  localparam int INT_W     = 29;
  localparam int GAIN_W    = 24;
  localparam int TOL_W     = 18;
  localparam int FORCE_W   = 32;
  localparam int PROD_P_W  = GAIN_W + 1 + ERR_W;
  localparam int PROD_I_W  = GAIN_W + 1 + INT_W;
  localparam int PROD_D_W  = GAIN_W + 1 + CHG_W;
  localparam int ACC_W     = PROD_I_W + 2;
  localparam int FRAC_SHIFT = 12;
  localparam int IN_DATA_W  = 120;
  localparam int OUT_DATA_W = 104;

  localparam logic signed [INT_W:0] INTEGRAL_LIMIT = 30'sd209715200;

  localparam logic [GAIN_W-1:0] KP_XY_RST = 24'd28160;
  localparam logic [GAIN_W-1:0] KI_XY_RST = 24'd77;
  localparam logic [GAIN_W-1:0] KD_XY_RST = 24'd589568;
  localparam logic [GAIN_W-1:0] KP_Z_RST  = 24'd28416;
  localparam logic [GAIN_W-1:0] KI_Z_RST  = 24'd51;
  localparam logic [GAIN_W-1:0] KD_Z_RST  = 24'd1152000;
  localparam logic [TOL_W-1:0]  POS_TOL_RST  = 18'd5243;
  localparam logic [TOL_W-1:0]  RATE_TOL_RST = 18'd1049;

  typedef enum logic [2:0] {
    CFG_KP_XY    = 3'd0,
    CFG_KI_XY    = 3'd1,
    CFG_KD_XY    = 3'd2,
    CFG_KP_Z     = 3'd3,
    CFG_KI_Z     = 3'd4,
    CFG_KD_Z     = 3'd5,
    CFG_POS_TOL  = 3'd6,
    CFG_RATE_TOL = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] ki;
    logic [GAIN_W-1:0] kd;
  } gains_t;

  typedef struct packed {
    logic ld1;
    logic ld2;
  } lane_ctrl_t;

  typedef struct packed {
    logic signed [PROD_P_W-1:0] prod_p;
    logic signed [PROD_I_W-1:0] prod_i;
    logic signed [PROD_D_W-1:0] prod_d;
    logic                       settled;
  } lane_res_t;

endpackage

### src/tpfc_lane.sv
// One axis lane: error, change and clamped sum, then the three gain products.
// Depends on tpfc_pkg.
module tpfc_lane (
  input  logic                                clk,
  input  logic                                rst,
  input  tpfc_pkg::lane_ctrl_t                ctrl,
  input  logic signed [tpfc_pkg::POS_W-1:0]   target,
  input  logic signed [tpfc_pkg::POS_W-1:0]   measured,
  input  tpfc_pkg::gains_t                    gains,
  input  logic [tpfc_pkg::TOL_W-1:0]          position_tolerance,
  input  logic [tpfc_pkg::TOL_W-1:0]          rate_tolerance,
  output tpfc_pkg::lane_res_t                 res
);

  localparam int ERR_W = tpfc_pkg::ERR_W;
  localparam int CHG_W = tpfc_pkg::CHG_W;
  localparam int INT_W = tpfc_pkg::INT_W;

  // axis state
  logic signed [ERR_W-1:0] prev_error;
  logic signed [INT_W-1:0] integral;

  // first stage
  logic signed [ERR_W-1:0] err_q;
  logic signed [CHG_W-1:0] chg_q;
  logic signed [INT_W-1:0] sum_q;
  logic                    settled_q;

  logic signed [ERR_W-1:0] err_next;
  logic signed [CHG_W-1:0] chg_next;
  logic signed [INT_W:0]   sum_wide;
  logic signed [INT_W-1:0] sum_next;
  logic [ERR_W-1:0]        err_mag;
  logic [CHG_W-1:0]        chg_mag;
  logic                    settled_next;

  always_comb begin
    err_next = ERR_W'(target) - ERR_W'(measured);
    chg_next = CHG_W'(err_next) - CHG_W'(prev_error);
    sum_wide = (INT_W+1)'(integral) + (INT_W+1)'(err_next);
    if (sum_wide > tpfc_pkg::INTEGRAL_LIMIT) begin
      sum_next = INT_W'(tpfc_pkg::INTEGRAL_LIMIT);
    end else if (sum_wide < -tpfc_pkg::INTEGRAL_LIMIT) begin
      sum_next = INT_W'(-tpfc_pkg::INTEGRAL_LIMIT);
    end else begin
      sum_next = INT_W'(sum_wide);
    end
    err_mag = err_next[ERR_W-1] ? ERR_W'(-err_next) : ERR_W'(err_next);
    chg_mag = chg_next[CHG_W-1] ? CHG_W'(-chg_next) : CHG_W'(chg_next);
    settled_next = (err_mag <= ERR_W'(position_tolerance)) &&
                   (chg_mag <= CHG_W'(rate_tolerance));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_error <= '0;
      integral   <= '0;
    end else if (ctrl.ld1) begin
      prev_error <= err_next;
      integral   <= sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld1) begin
      err_q     <= err_next;
      chg_q     <= chg_next;
      sum_q     <= sum_next;
      settled_q <= settled_next;
    end
  end

  // second stage: gains are unsigned, so widen each with a zero sign bit
  always_ff @(posedge clk) begin
    if (ctrl.ld2) begin
      res.prod_p  <= $signed({1'b0, gains.kp}) * err_q;
      res.prod_i  <= $signed({1'b0, gains.ki}) * sum_q;
      res.prod_d  <= $signed({1'b0, gains.kd}) * chg_q;
      res.settled <= settled_q;
    end
  end

endmodule

### src/tpfc_merge.sv
// Merge stage: sum each lane's products, round, saturate, and combine flags.
// Depends on tpfc_pkg.
module tpfc_merge (
  input  logic                                  clk,
  input  logic                                  ld,
  input  tpfc_pkg::lane_res_t                   res [tpfc_pkg::AXES],
  output logic [tpfc_pkg::OUT_DATA_W-1:0]       data
);

  localparam int ACC_W   = tpfc_pkg::ACC_W;
  localparam int FORCE_W = tpfc_pkg::FORCE_W;
  localparam int SH_W    = ACC_W - tpfc_pkg::FRAC_SHIFT;
  localparam logic signed [SH_W-1:0] F_MAX = SH_W'(64'sd2147483647);
  localparam logic signed [SH_W-1:0] F_MIN = SH_W'(-64'sd2147483648);
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (tpfc_pkg::FRAC_SHIFT - 1);

  logic signed [ACC_W-1:0]   acc     [tpfc_pkg::AXES];
  logic signed [ACC_W-1:0]   shifted [tpfc_pkg::AXES];
  logic signed [SH_W-1:0]    scaled  [tpfc_pkg::AXES];
  logic [FORCE_W-1:0]        force_next [tpfc_pkg::AXES];
  logic                      all_settled;

  always_comb begin
    all_settled = 1'b1;
    for (int i = 0; i < tpfc_pkg::AXES; i++) begin
      acc[i] = ACC_W'(res[i].prod_p) + ACC_W'(res[i].prod_i) +
               ACC_W'(res[i].prod_d) + HALF;
      shifted[i] = acc[i] >>> tpfc_pkg::FRAC_SHIFT;
      scaled[i]  = shifted[i][SH_W-1:0];
      if (scaled[i] > F_MAX) begin
        force_next[i] = FORCE_W'(F_MAX);
      end else if (scaled[i] < F_MIN) begin
        force_next[i] = FORCE_W'(F_MIN);
      end else begin
        force_next[i] = FORCE_W'(scaled[i]);
      end
      all_settled = all_settled & res[i].settled;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      data <= {7'b0, all_settled, force_next[2], force_next[1], force_next[0]};
    end
  end

endmodule

### src/three_axis_pid_force_controller_top.sv
// Three-axis PID force controller: three axis lanes feeding one merge stage.
// Pipeline: 3 register stages; an accepted word passes the error registers, the gain
// products and the output register in turn. Throughput: one word per cycle; each of the
// three stages (error and clamp, gain multiply, sum and saturate) holds its word until
// the next frees up. Reset (synchronous, rst high): gains and tolerances to defaults,
// error history and error sums to zero, pipeline emptied. Depends on tpfc_pkg, tpfc_lane, tpfc_merge.
module three_axis_pid_force_controller_top (
  input  logic                               clk,
  input  logic                               rst,
  // input stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // target_x, target_y, target_z, measured_x, measured_y, measured_z (19 bits each),
  // zero fill in [119:114]
  input  logic [tpfc_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // force_x [31:0], force_y [63:32], force_z [95:64], at_position [96],
  // zero fill in [103:97]
  output logic [tpfc_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // configuration write port
  input  logic                               cfg_we,
  input  logic [2:0]                         cfg_addr,
  input  logic [tpfc_pkg::GAIN_W-1:0]        cfg_data
);

  localparam int AXES  = tpfc_pkg::AXES;
  localparam int POS_W = tpfc_pkg::POS_W;

  // ---------------------------------------------------------------------------
  // Configuration registers. Hold the value until the next write to the index.
  // ---------------------------------------------------------------------------
  tpfc_pkg::gains_t               gains_xy;
  tpfc_pkg::gains_t               gains_z;
  logic [tpfc_pkg::TOL_W-1:0]     position_tolerance;
  logic [tpfc_pkg::TOL_W-1:0]     rate_tolerance;

  always_ff @(posedge clk) begin
    if (rst) begin
      gains_xy.kp        <= tpfc_pkg::KP_XY_RST;
      gains_xy.ki        <= tpfc_pkg::KI_XY_RST;
      gains_xy.kd        <= tpfc_pkg::KD_XY_RST;
      gains_z.kp         <= tpfc_pkg::KP_Z_RST;
      gains_z.ki         <= tpfc_pkg::KI_Z_RST;
      gains_z.kd         <= tpfc_pkg::KD_Z_RST;
      position_tolerance <= tpfc_pkg::POS_TOL_RST;
      rate_tolerance     <= tpfc_pkg::RATE_TOL_RST;
    end else if (cfg_we) begin
      case (tpfc_pkg::cfg_idx_t'(cfg_addr))
        tpfc_pkg::CFG_KP_XY:    gains_xy.kp <= cfg_data;
        tpfc_pkg::CFG_KI_XY:    gains_xy.ki <= cfg_data;
        tpfc_pkg::CFG_KD_XY:    gains_xy.kd <= cfg_data;
        tpfc_pkg::CFG_KP_Z:     gains_z.kp  <= cfg_data;
        tpfc_pkg::CFG_KI_Z:     gains_z.ki  <= cfg_data;
        tpfc_pkg::CFG_KD_Z:     gains_z.kd  <= cfg_data;
        // tolerances keep only their low bits
        tpfc_pkg::CFG_POS_TOL:  position_tolerance <= cfg_data[tpfc_pkg::TOL_W-1:0];
        tpfc_pkg::CFG_RATE_TOL: rate_tolerance     <= cfg_data[tpfc_pkg::TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control. Each stage loads when it is empty or its word moves on,
  // so a result waiting at the output stops the stages behind it only once
  // they are full.
  // ---------------------------------------------------------------------------
  logic                  v1, v2, v3;
  logic                  rdy1, rdy2, rdy3;
  tpfc_pkg::lane_ctrl_t  lane_ctrl;

  assign rdy3 = !v3 || m_axis_tready;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;

  assign s_axis_tready = rdy1;
  assign m_axis_tvalid = v3;

  // ld1 also advances the per-axis error history and error sums
  assign lane_ctrl.ld1 = s_axis_tvalid && rdy1;
  assign lane_ctrl.ld2 = v1 && rdy2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= s_axis_tvalid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  // ---------------------------------------------------------------------------
  // Axis lanes. X and Y share one gain set, Z has its own.
  // ---------------------------------------------------------------------------
  tpfc_pkg::lane_res_t lane_res [AXES];

  for (genvar a = 0; a < AXES; a++) begin : g_lane
    tpfc_lane u_lane (
      .clk                (clk),
      .rst                (rst),
      .ctrl               (lane_ctrl),
      .target             (s_axis_tdata[POS_W*a +: POS_W]),
      .measured           (s_axis_tdata[POS_W*(a+AXES) +: POS_W]),
      .gains              ((a < 2) ? gains_xy : gains_z),
      .position_tolerance (position_tolerance),
      .rate_tolerance     (rate_tolerance),
      .res                (lane_res[a])
    );
  end

  // ---------------------------------------------------------------------------
  // Merge: round and saturate each force, AND the settled flags, drive the
  // output register directly.
  // ---------------------------------------------------------------------------
  tpfc_merge u_merge (
    .clk  (clk),
    .ld   (v2 && rdy3),
    .res  (lane_res),
    .data (m_axis_tdata)
  );

endmodule

### src/tpfc_checker.sv
// Port-level checker for the three-axis PID force controller, bound to the top.
// Depends on three_axis_pid_force_controller_top_assert.svh.
`include "three_axis_pid_force_controller_top_assert.svh"

module tpfc_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [103:0] m_axis_tdata
);

  logic in_acc;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // a result word held back by the sink keeps its value
  `TPFC_ASSERT(a_out_hold, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)), "output word changed while stalled")

  // the block leaves reset with nothing to show
  `TPFC_ASSERT_ALWAYS(a_rst_empty, rst |=> !m_axis_tvalid, "output valid right after reset")

  // with the output slot free, the whole pipeline can move, so input is taken
  `TPFC_ASSERT(a_free_ready, !m_axis_tvalid |-> s_axis_tready, "input stalled with empty output")

  // with no input taken and a ready sink throughout, every word drains
  `TPFC_ASSERT(a_drain, (!in_acc && m_axis_tready) ##1 (!in_acc && m_axis_tready) ##1 (!in_acc && m_axis_tready) |=> !m_axis_tvalid, "pipeline did not drain")

endmodule

bind three_axis_pid_force_controller_top tpfc_checker u_tpfc_checker (.*);

### test/tb_three_axis_pid_force_controller_top.sv
// Self-checking testbench for the three-axis PID force controller top level.
// Drives the input word stream and the register port and predicts each result word.
// Depends on tpfc_pkg and three_axis_pid_force_controller_top.
module tb_three_axis_pid_force_controller_top;

  localparam int AXES        = tpfc_pkg::AXES;
  localparam int POS_W       = tpfc_pkg::POS_W;
  localparam int TOL_W       = tpfc_pkg::TOL_W;
  localparam int GAIN_W      = tpfc_pkg::GAIN_W;
  localparam int FORCE_W     = tpfc_pkg::FORCE_W;
  localparam int FRAC_SHIFT  = tpfc_pkg::FRAC_SHIFT;
  localparam int IN_DATA_W   = tpfc_pkg::IN_DATA_W;
  localparam int OUT_DATA_W  = tpfc_pkg::OUT_DATA_W;

  localparam int SAT_ROW         = 13;    // first directed row run with saturating gains
  localparam int NUM_ROWS        = 18;
  localparam int RANDOM_PER_PLAN = 262;
  localparam int TAIL_CYCLES     = 12;
  localparam int WATCHDOG_LIMIT  = 5000;

  localparam logic [POS_W-1:0]   POS_MAX  = 19'h3FFFF;
  localparam logic [POS_W-1:0]   POS_MIN  = 19'h40000;
  localparam logic [FORCE_W-1:0] FORCE_HI = 32'h7FFFFFFF;
  localparam logic [FORCE_W-1:0] FORCE_LO = 32'h80000000;
  localparam logic [GAIN_W-1:0]  ALL_ONES = 24'hFFFFFF;

  // One result word, laid out as on m_axis_tdata (force_x in the low bits).
  typedef struct packed {
    logic               flag;
    logic [FORCE_W-1:0] fz;
    logic [FORCE_W-1:0] fy;
    logic [FORCE_W-1:0] fx;
  } force_word_t;

  // One directed row: positions, and a typed result where it is obvious.
  typedef struct packed {
    logic [POS_W-1:0]   tx, ty, tz, mx, my, mz;
    logic               typed;
    logic               flag;
    logic [FORCE_W-1:0] fx, fy, fz;
  } stim_row_t;

  typedef enum {SET_DEFAULTS, SET_ZERO, SET_MAX, SET_MODEST, SET_WIDE,
                SET_INTEGRAL_HEAVY, SET_SATURATE} gain_plan_t;
  typedef enum {SEG_PUSH, SEG_SETTLE, SEG_NOISE} segment_t;
  typedef enum {RX_OPEN, RX_COIN, RX_TIGHT, RX_PATTERN} rx_mode_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we = 1'b0;
  logic [2:0]            cfg_addr = tpfc_pkg::CFG_KP_XY;
  logic [GAIN_W-1:0]     cfg_data = '0;

  three_axis_pid_force_controller_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data)
  );

  always #6 clk = ~clk;

  // Shadow copy of the register file, written in step with the port.
  logic [GAIN_W-1:0] kp_xy_q = tpfc_pkg::KP_XY_RST;
  logic [GAIN_W-1:0] ki_xy_q = tpfc_pkg::KI_XY_RST;
  logic [GAIN_W-1:0] kd_xy_q = tpfc_pkg::KD_XY_RST;
  logic [GAIN_W-1:0] kp_z_q  = tpfc_pkg::KP_Z_RST;
  logic [GAIN_W-1:0] ki_z_q  = tpfc_pkg::KI_Z_RST;
  logic [GAIN_W-1:0] kd_z_q  = tpfc_pkg::KD_Z_RST;
  logic [TOL_W-1:0]  pos_tol_q  = tpfc_pkg::POS_TOL_RST;
  logic [TOL_W-1:0]  rate_tol_q = tpfc_pkg::RATE_TOL_RST;

  // Per-axis controller history: last error and clamped error sum.
  longint prev_err_q [AXES];
  longint err_sum_q  [AXES];

  force_word_t pending_forces [$];

  int words_sent       = 0;
  int results_checked  = 0;
  int mismatches       = 0;
  int settings_applied = 0;
  int clamp_hits       = 0;
  int sat_hits         = 0;
  int settled_hits     = 0;
  int burst_left       = 0;
  int idle_cycles      = 0;

  // Directed rows. Results are typed in only after reset (all zero) and where
  // the saturating gains leave no doubt; the predictor covers the rest.
  stim_row_t directed_rows [NUM_ROWS] = '{
    // reset gains: zero error right after reset gives zero force, at position
    '{19'd0, 19'd0, 19'd0, 19'd0, 19'd0, 19'd0, 1'b1, 1'b1, 32'd0, 32'd0, 32'd0},
    '{19'd0, 19'd0, 19'd0, 19'd0, 19'd0, 19'd0, 1'b1, 1'b1, 32'd0, 32'd0, 32'd0},
    // largest positive, then largest negative error on every axis
    '{POS_MAX, POS_MAX, POS_MAX, POS_MIN, POS_MIN, POS_MIN, 1'b0, 1'b0, '0, '0, '0},
    '{POS_MIN, POS_MIN, POS_MIN, POS_MAX, POS_MAX, POS_MAX, 1'b0, 1'b0, '0, '0, '0},
    // zero error with the largest error change, then zero change
    '{POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX, 1'b0, 1'b0, '0, '0, '0},
    '{POS_MIN, POS_MIN, POS_MIN, POS_MIN, POS_MIN, POS_MIN, 1'b0, 1'b0, '0, '0, '0},
    // Z error right on the position tolerance; repeat to settle the rate
    '{19'd100, -19'sd100, 19'd5243, 19'd0, 19'd0, 19'd0, 1'b0, 1'b0, '0, '0, '0},
    '{19'd100, -19'sd100, 19'd5243, 19'd0, 19'd0, 19'd0, 1'b0, 1'b0, '0, '0, '0},
    // one past the tolerance
    '{19'd100, -19'sd100, 19'd5244, 19'd0, 19'd0, 19'd0, 1'b0, 1'b0, '0, '0, '0},
    // X and Y driven to opposite extremes, Z idle
    '{POS_MAX, POS_MIN, 19'd0, POS_MIN, POS_MAX, 19'd0, 1'b0, 1'b0, '0, '0, '0},
    // alternating bit patterns in every field
    '{19'h2AAAA, 19'h55555, 19'h2AAAA, 19'h55555, 19'h2AAAA, 19'h55555,
      1'b0, 1'b0, '0, '0, '0},
    '{19'h55555, 19'h2AAAA, 19'h55555, 19'h2AAAA, 19'h55555, 19'h2AAAA,
      1'b0, 1'b0, '0, '0, '0},
    '{19'd0, 19'd0, 19'd0, 19'd0, 19'd0, 19'd0, 1'b0, 1'b0, '0, '0, '0},
    // saturating gains (kp, kd at full scale, ki zero): clip high and low
    '{19'd0, 19'd0, 19'd0, 19'd0, 19'd0, 19'd0, 1'b1, 1'b1, 32'd0, 32'd0, 32'd0},
    '{POS_MAX, POS_MAX, POS_MAX, POS_MIN, POS_MIN, POS_MIN,
      1'b1, 1'b0, FORCE_HI, FORCE_HI, FORCE_HI},
    '{POS_MIN, POS_MIN, POS_MIN, POS_MAX, POS_MAX, POS_MAX,
      1'b1, 1'b0, FORCE_LO, FORCE_LO, FORCE_LO},
    '{POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX, 1'b0, 1'b0, '0, '0, '0},
    '{19'd0, 19'd0, 19'd0, 19'd0, 19'd0, 19'd0, 1'b1, 1'b1, 32'd0, 32'd0, 32'd0}
  };

  // Advance the controller by one sample and return the force word it drives.
  function automatic force_word_t predict_forces(input logic [IN_DATA_W-1:0] w);
    force_word_t      r;
    logic [FORCE_W-1:0] f32 [AXES];
    longint           err, chg, sum, acc, f, kp, ki, kd, lim;
    logic             settled;
    settled = 1'b1;
    lim = longint'(tpfc_pkg::INTEGRAL_LIMIT);
    for (int a = 0; a < AXES; a++) begin
      err = longint'($signed(w[POS_W*a +: POS_W]))
          - longint'($signed(w[POS_W*(a+AXES) +: POS_W]));
      chg = err - prev_err_q[a];
      sum = err_sum_q[a] + err;
      if (sum > lim || sum < -lim) clamp_hits++;
      if (sum > lim) sum = lim;
      if (sum < -lim) sum = -lim;
      err_sum_q[a] = sum;
      prev_err_q[a] = err;
      // X and Y share a gain set, Z has its own
      if (a < 2) begin
        kp = longint'(kp_xy_q); ki = longint'(ki_xy_q); kd = longint'(kd_xy_q);
      end else begin
        kp = longint'(kp_z_q); ki = longint'(ki_z_q); kd = longint'(kd_z_q);
      end
      acc = kp * err + ki * sum + kd * chg;
      // round half up into 2^-16 N, then clip to 32 bits
      f = (acc + (longint'(1) <<< (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
      if (f > longint'(32'sh7FFFFFFF) || f < -longint'(33'sh080000000)) sat_hits++;
      if (f > longint'(32'sh7FFFFFFF)) f = longint'(32'sh7FFFFFFF);
      if (f < -longint'(33'sh080000000)) f = -longint'(33'sh080000000);
      f32[a] = f[FORCE_W-1:0];
      if ((err < 0 ? -err : err) > longint'(pos_tol_q) ||
          (chg < 0 ? -chg : chg) > longint'(rate_tol_q))
        settled = 1'b0;
    end
    if (settled) settled_hits++;
    r.fx = f32[0];
    r.fy = f32[1];
    r.fz = f32[2];
    r.flag = settled;
    return r;
  endfunction

  function automatic longint pick(input longint lo, input longint hi);
    return lo + longint'($urandom_range(0, 32'(hi - lo)));
  endfunction

  // Clip a position to the 19-bit field.
  function automatic logic [POS_W-1:0] fit_pos(input longint v);
    if (v > 262143) v = 262143;
    if (v < -262144) v = -262144;
    return v[POS_W-1:0];
  endfunction

  task automatic report_mismatch(input string field, input logic [FORCE_W-1:0] got,
                                 input logic [FORCE_W-1:0] want);
    $display("tb: result %0d, %s: got %h, want %h", results_checked, field, got, want);
    mismatches++;
  endtask

  // Hand one word to the block, honoring the burst/gap pattern of the sender.
  // Call at a rising edge; returns at the edge that accepted the word.
  task automatic send_word(input logic [IN_DATA_W-1:0] w, input logic typed,
                           input force_word_t typed_want);
    force_word_t want;
    int          gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      case ($urandom_range(0, 3))
        0:       gap = 0;
        1, 2:    gap = $urandom_range(1, 4);
        default: gap = $urandom_range(5, 20);
      endcase
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    do @(posedge clk); while (!s_axis_tready);
    want = predict_forces(w);
    if (typed) want = typed_want;
    pending_forces.push_back(want);
    words_sent++;
  endtask

  // Drop valid and hold until every predicted word has come out.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_forces.size() != 0) @(posedge clk);
  endtask

  // Write one register; the write lands at the next rising edge.
  task automatic write_reg(input tpfc_pkg::cfg_idx_t idx, input logic [GAIN_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      tpfc_pkg::CFG_KP_XY:    kp_xy_q = val;
      tpfc_pkg::CFG_KI_XY:    ki_xy_q = val;
      tpfc_pkg::CFG_KD_XY:    kd_xy_q = val;
      tpfc_pkg::CFG_KP_Z:     kp_z_q  = val;
      tpfc_pkg::CFG_KI_Z:     ki_z_q  = val;
      tpfc_pkg::CFG_KD_Z:     kd_z_q  = val;
      tpfc_pkg::CFG_POS_TOL:  pos_tol_q  = val[TOL_W-1:0];  // upper bits are dropped
      tpfc_pkg::CFG_RATE_TOL: rate_tol_q = val[TOL_W-1:0];
      default: ;
    endcase
  endtask

  // Load all eight registers for one gain plan. Only call with the block idle.
  task automatic apply_plan(input gain_plan_t plan);
    logic [GAIN_W-1:0] vals [8];
    case (plan)
      SET_DEFAULTS: begin
        vals[tpfc_pkg::CFG_KP_XY] = tpfc_pkg::KP_XY_RST;
        vals[tpfc_pkg::CFG_KI_XY] = tpfc_pkg::KI_XY_RST;
        vals[tpfc_pkg::CFG_KD_XY] = tpfc_pkg::KD_XY_RST;
        vals[tpfc_pkg::CFG_KP_Z]  = tpfc_pkg::KP_Z_RST;
        vals[tpfc_pkg::CFG_KI_Z]  = tpfc_pkg::KI_Z_RST;
        vals[tpfc_pkg::CFG_KD_Z]  = tpfc_pkg::KD_Z_RST;
        vals[tpfc_pkg::CFG_POS_TOL]  = GAIN_W'(tpfc_pkg::POS_TOL_RST);
        vals[tpfc_pkg::CFG_RATE_TOL] = GAIN_W'(tpfc_pkg::RATE_TOL_RST);
      end
      SET_ZERO: foreach (vals[k]) vals[k] = '0;
      SET_MAX:  foreach (vals[k]) vals[k] = ALL_ONES;  // tolerances keep 18 bits
      SET_MODEST: begin
        foreach (vals[k]) vals[k] = GAIN_W'($urandom_range(0, 65535));
        vals[tpfc_pkg::CFG_POS_TOL]  = GAIN_W'($urandom_range(0, 8000));
        vals[tpfc_pkg::CFG_RATE_TOL] = GAIN_W'($urandom_range(0, 3000));
      end
      SET_WIDE: foreach (vals[k]) vals[k] = GAIN_W'($urandom);
      SET_INTEGRAL_HEAVY: begin
        foreach (vals[k]) vals[k] = GAIN_W'($urandom_range(0, 4096));
        vals[tpfc_pkg::CFG_KI_XY] = GAIN_W'($urandom_range(1024, 8192));
        vals[tpfc_pkg::CFG_KI_Z]  = GAIN_W'($urandom_range(1024, 8192));
        vals[tpfc_pkg::CFG_POS_TOL]  = GAIN_W'($urandom_range(0, 20000));
        vals[tpfc_pkg::CFG_RATE_TOL] = GAIN_W'($urandom_range(0, 20000));
      end
      default: begin
        // saturating: full-scale P and D, no I, default tolerances
        vals[tpfc_pkg::CFG_KP_XY] = ALL_ONES;
        vals[tpfc_pkg::CFG_KI_XY] = '0;
        vals[tpfc_pkg::CFG_KD_XY] = ALL_ONES;
        vals[tpfc_pkg::CFG_KP_Z]  = ALL_ONES;
        vals[tpfc_pkg::CFG_KI_Z]  = '0;
        vals[tpfc_pkg::CFG_KD_Z]  = ALL_ONES;
        vals[tpfc_pkg::CFG_POS_TOL]  = GAIN_W'(tpfc_pkg::POS_TOL_RST);
        vals[tpfc_pkg::CFG_RATE_TOL] = GAIN_W'(tpfc_pkg::RATE_TOL_RST);
      end
    endcase
    for (int k = 0; k < 8; k++) write_reg(tpfc_pkg::cfg_idx_t'(k), vals[k]);
    cfg_we <= 1'b0;
    settings_applied++;
  endtask

  // Random traffic in segments: long same-sign pushes that run the error sum
  // into its clamp, slow drifts around the set point that toggle the at-position
  // flag, and short bursts of raw noise on every bit.
  task automatic run_random(input int n_words);
    logic [IN_DATA_W-1:0] w;
    segment_t seg;
    int       seg_len, done, roll;
    longint   push_sign, rstep, step, ptol;
    longint   base [AXES];
    longint   offs [AXES];
    done = 0;
    push_sign = 1;
    while (done < n_words) begin
      roll = $urandom_range(0, 99);
      seg = (roll < 35) ? SEG_PUSH : (roll < 70) ? SEG_SETTLE : SEG_NOISE;
      case (seg)
        SEG_PUSH:   seg_len = $urandom_range(150, 450);
        SEG_SETTLE: seg_len = $urandom_range(20, 120);
        default:    seg_len = $urandom_range(1, 30);
      endcase
      if (seg == SEG_PUSH && $urandom_range(0, 9) < 3) push_sign = -push_sign;
      ptol = longint'(pos_tol_q);
      for (int a = 0; a < AXES; a++) begin
        base[a] = pick(-262144, 262143);
        offs[a] = pick(-ptol, ptol);
      end
      for (int j = 0; j < seg_len && done < n_words; j++) begin
        w = '0;
        for (int a = 0; a < AXES; a++) begin
          if (seg == SEG_NOISE || $urandom_range(0, 49) == 0) begin
            // raw noise, and the odd broken sample inside a sequence
            w[POS_W*a +: POS_W] = POS_W'($urandom);
            w[POS_W*(a+AXES) +: POS_W] = POS_W'($urandom);
          end else if (seg == SEG_PUSH) begin
            w[POS_W*a +: POS_W] = fit_pos(push_sign * (262143 - pick(0, 2000)));
            w[POS_W*(a+AXES) +: POS_W] = fit_pos(-push_sign * (262144 - pick(0, 2000)));
          end else begin
            // hold still a third of the time so the rate check can pass
            rstep = longint'(rate_tol_q) + 2;
            step = ($urandom_range(0, 2) == 0) ? 0 : pick(-rstep, rstep);
            offs[a] = offs[a] + step;
            if (offs[a] > ptol + 2) offs[a] = ptol + 2;
            if (offs[a] < -ptol - 2) offs[a] = -ptol - 2;
            w[POS_W*a +: POS_W] = fit_pos(base[a]);
            w[POS_W*(a+AXES) +: POS_W] = fit_pos(base[a] - offs[a]);
          end
        end
        send_word(w, 1'b0, '0);
        done++;
      end
    end
  endtask

  // Receiver: stall on a pattern that changes every so often.
  rx_mode_t rx_mode  = RX_OPEN;
  int       rx_left  = 0;
  logic [7:0] rx_mask  = 8'hFF;
  logic [2:0] rx_phase = '0;

  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_left <= $urandom_range(16, 200);
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_mask <= 8'($urandom) | 8'h01;
    end else begin
      rx_left <= rx_left - 1;
    end
    rx_phase <= rx_phase + 3'd1;
    case (rx_mode)
      RX_OPEN:  m_axis_tready <= 1'b1;
      RX_COIN:  m_axis_tready <= 1'($urandom_range(0, 1));
      RX_TIGHT: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default:  m_axis_tready <= rx_mask[rx_phase];
    endcase
  end

  // Compare every accepted result word with the oldest prediction.
  always @(posedge clk) begin
    force_word_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_forces.size() == 0) begin
        report_mismatch("word with nothing pending, force_x", m_axis_tdata[31:0], '0);
      end else begin
        want = pending_forces.pop_front();
        if (m_axis_tdata[31:0] !== want.fx)
          report_mismatch("force_x", m_axis_tdata[31:0], want.fx);
        if (m_axis_tdata[63:32] !== want.fy)
          report_mismatch("force_y", m_axis_tdata[63:32], want.fy);
        if (m_axis_tdata[95:64] !== want.fz)
          report_mismatch("force_z", m_axis_tdata[95:64], want.fz);
        if (m_axis_tdata[96] !== want.flag)
          report_mismatch("at_position", 32'(m_axis_tdata[96]), 32'(want.flag));
      end
      results_checked++;
    end
  end

  // Watchdog: end the run if no word moves on either side for too long.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: timeout after %0d idle cycles", idle_cycles);
      $display("tb: failure");
      $finish;
    end
  end

  gain_plan_t plan_order [7] = '{SET_DEFAULTS, SET_ZERO, SET_MAX, SET_MODEST,
                                 SET_WIDE, SET_INTEGRAL_HEAVY, SET_DEFAULTS};

  initial begin
    stim_row_t r;
    foreach (prev_err_q[a]) begin
      prev_err_q[a] = 0;
      err_sum_q[a]  = 0;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed rows under reset gains, then under saturating gains.
    for (int i = 0; i < NUM_ROWS; i++) begin
      if (i == SAT_ROW) begin
        wait_drained();
        apply_plan(SET_SATURATE);
      end
      r = directed_rows[i];
      send_word({6'b0, r.mz, r.my, r.mx, r.tz, r.ty, r.tx}, r.typed,
                {r.flag, r.fz, r.fy, r.fx});
    end

    // Random traffic under each gain plan; reprogram only once drained.
    foreach (plan_order[p]) begin
      wait_drained();
      apply_plan(plan_order[p]);
      run_random(RANDOM_PER_PLAN);
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("tb: %0d words in, %0d results checked across %0d register settings",
             words_sent, results_checked, settings_applied);
    $display("tb: error sum clamped %0d times, force clipped %0d times, %0d at position",
             clamp_hits, sat_hits, settled_hits);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: %0d mismatches", mismatches);
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+src
src/tpfc_pkg.sv
src/tpfc_lane.sv
src/tpfc_merge.sv
src/three_axis_pid_force_controller_top.sv
src/tpfc_checker.sv
test/tb_three_axis_pid_force_controller_top.sv
